// ----- rtl/core/ogii_pkg.sv -----
// shared types, constants and helpers for the oriented gradient integral image block
`timescale 1ns / 1ps
package ogii_pkg;

    localparam int NBINS = 9;
    localparam int SUM_W = 40;
    localparam int PIX_W = 16;
    localparam int CX_W  = 30;
    localparam int CZ_W  = 22;
    localparam int MAG_W = 22;
    localparam int ANG_W = 20;

    localparam logic [SUM_W-1:0]       SUM_MAX     = {SUM_W{1'b1}};
    localparam logic signed [CZ_W-1:0] ANG_PI      = 22'sd589824;
    localparam logic signed [CZ_W-1:0] ANG_HALF_PI = 22'sd294912;
    localparam logic [23:0]            KINV_Q24    = 24'd10188014;

    typedef logic [NBINS-1:0][SUM_W-1:0] t_sums;

    // configuration register indexes
    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    // request into the cordic unit
    typedef struct packed {
        logic                   start;
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [CZ_W-1:0] z;
    } t_cord_req;

    // result from the cordic unit
    typedef struct packed {
        logic                   done;
        logic signed [CX_W-1:0] x;
        logic signed [CZ_W-1:0] z;
    } t_cord_rsp;

    // arctangent of 2^-i in bin units with 16 fraction bits
    function automatic logic signed [CZ_W-1:0] atan_bins(input logic [4:0] idx);
        logic signed [CZ_W-1:0] v;
        case (idx)
            5'd0:    v = 22'sd147456;
            5'd1:    v = 22'sd87048;
            5'd2:    v = 22'sd45994;
            5'd3:    v = 22'sd23347;
            5'd4:    v = 22'sd11719;
            5'd5:    v = 22'sd5865;
            5'd6:    v = 22'sd2933;
            5'd7:    v = 22'sd1467;
            5'd8:    v = 22'sd733;
            5'd9:    v = 22'sd367;
            5'd10:   v = 22'sd183;
            5'd11:   v = 22'sd92;
            5'd12:   v = 22'sd46;
            5'd13:   v = 22'sd23;
            5'd14:   v = 22'sd11;
            5'd15:   v = 22'sd6;
            5'd16:   v = 22'sd3;
            5'd17:   v = 22'sd1;
            5'd18:   v = 22'sd1;
            default: v = 22'sd0;
        endcase
        return v;
    endfunction

    // saturating add of two sums
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

// ----- rtl/core/ogii_if.sv -----
// stream interfaces for pixels in and integral sums out
`timescale 1ns / 1ps
interface ogii_pix_if;
    logic                                valid;
    logic                                ready;
    logic signed [ogii_pkg::PIX_W-1:0]   filtered_pixel;
    modport source(output valid, output filtered_pixel, input ready);
    modport sink(input valid, input filtered_pixel, output ready);
endinterface

interface ogii_res_if;
    logic                         valid;
    logic                         ready;
    logic [ogii_pkg::SUM_W-1:0]   bin_sum_0;
    logic [ogii_pkg::SUM_W-1:0]   bin_sum_1;
    logic [ogii_pkg::SUM_W-1:0]   bin_sum_2;
    logic [ogii_pkg::SUM_W-1:0]   bin_sum_3;
    logic [ogii_pkg::SUM_W-1:0]   bin_sum_4;
    logic [ogii_pkg::SUM_W-1:0]   bin_sum_5;
    logic [ogii_pkg::SUM_W-1:0]   bin_sum_6;
    logic [ogii_pkg::SUM_W-1:0]   bin_sum_7;
    logic [ogii_pkg::SUM_W-1:0]   bin_sum_8;
    logic [9:0]                   out_column;
    logic [9:0]                   out_row;
    logic                         last_of_run;
    modport source(output valid, output bin_sum_0, output bin_sum_1, output bin_sum_2,
                   output bin_sum_3, output bin_sum_4, output bin_sum_5, output bin_sum_6,
                   output bin_sum_7, output bin_sum_8, output out_column, output out_row,
                   output last_of_run, input ready);
    modport sink(input valid, input bin_sum_0, input bin_sum_1, input bin_sum_2,
                 input bin_sum_3, input bin_sum_4, input bin_sum_5, input bin_sum_6,
                 input bin_sum_7, input bin_sum_8, input out_column, input out_row,
                 input last_of_run, output ready);
endinterface

// ----- rtl/core/ogii_linebuf.sv -----
// two pixel line buffers with registered neighbor reads
`timescale 1ns / 1ps
module ogii_linebuf #(
    parameter int DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rd_en,
    input  logic                                i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]            i_addr,
    input  logic signed [ogii_pkg::PIX_W-1:0]   i_wr_pix,
    output logic signed [ogii_pkg::PIX_W-1:0]   o_left,
    output logic signed [ogii_pkg::PIX_W-1:0]   o_up,
    output logic signed [ogii_pkg::PIX_W-1:0]   o_right
);
    localparam int AW = $clog2(DEPTH);

    logic signed [ogii_pkg::PIX_W-1:0] r_row1_mem [DEPTH];
    logic signed [ogii_pkg::PIX_W-1:0] r_row2_mem [DEPTH];
    logic signed [ogii_pkg::PIX_W-1:0] r_left, r_up, r_cur, r_right;
    logic [AW-1:0] addr_m1, addr_p1;

    // neighbor addresses kept in range
    assign addr_m1 = (i_addr == '0) ? '0 : i_addr - 1'b1;
    assign addr_p1 = (i_addr == AW'(DEPTH - 1)) ? '0 : i_addr + 1'b1;

    // reads at accept, shift of the column one row down later
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_left  <= r_row2_mem[addr_m1];
            r_up    <= r_row2_mem[i_addr];
            r_cur   <= r_row1_mem[i_addr];
            r_right <= r_row1_mem[addr_p1];
        end
        if (i_wr_en) begin
            r_row2_mem[i_addr] <= r_cur;
            r_row1_mem[i_addr] <= i_wr_pix;
        end
    end

    assign o_left  = r_left;
    assign o_up    = r_up;
    assign o_right = r_right;
endmodule

// ----- rtl/core/ogii_intmem.sv -----
// memory of the previous output row's nine integral sums per column
`timescale 1ns / 1ps
module ogii_intmem #(
    parameter int DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic                        i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]    i_addr,
    input  ogii_pkg::t_sums             i_wr_data,
    output ogii_pkg::t_sums             o_rd_data
);
    ogii_pkg::t_sums r_mem [DEPTH];
    ogii_pkg::t_sums r_rd;

    // one port, registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= r_mem[i_addr];
        end
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd;
endmodule

// ----- rtl/core/ogii_cordic.sv -----
// iterative vectoring cordic, one micro-rotation per cycle
`timescale 1ns / 1ps
module ogii_cordic #(
    parameter int STAGES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ogii_pkg::t_cord_req   i_req,
    output ogii_pkg::t_cord_rsp   o_rsp
);
    localparam int IW = (STAGES > 1) ? $clog2(STAGES) : 1;

    logic signed [ogii_pkg::CX_W-1:0] r_x, r_y, sx, sy;
    logic signed [ogii_pkg::CZ_W-1:0] r_z, atan;
    logic [IW-1:0] r_i;
    logic r_busy, r_done;

    // shifted terms and table angle for this step
    assign sx   = r_x >>> r_i;
    assign sy   = r_y >>> r_i;
    assign atan = ogii_pkg::atan_bins(5'(r_i));

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                if (r_i == IW'(STAGES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end

    // rotation datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x <= i_req.x;
            r_y <= i_req.y;
            r_z <= i_req.z;
        end else if (r_busy) begin
            if (!r_y[ogii_pkg::CX_W-1]) begin
                r_x <= r_x + sy;
                r_y <= r_y - sx;
                r_z <= r_z + atan;
            end else begin
                r_x <= r_x - sy;
                r_y <= r_y + sx;
                r_z <= r_z - atan;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.x    = r_x;
    assign o_rsp.z    = r_z;
endmodule

// ----- rtl/core/oriented_gradient_integral_images.sv -----
// Top level: takes filtered pixels in raster order and returns, one row behind,
// the 2D integral sums of nine orientation bins of the gradient magnitude. Each pixel
// is handled alone: a border pixel goes from IDLE through GRAD to SUM, an interior pixel
// also through the CORDIC unit, which does one micro-rotation per cycle, and then MAG, RND,
// HI and ACC, plus any wait for the output register to empty. Inputs of the last row give
// two results. The two line buffers and the row of previous integrals sit in memories
// with registered reads, indexed by column; they need no clearing after reset.
`timescale 1ns / 1ps
module oriented_gradient_integral_images #(
    parameter int MAX_WIDTH     = 1024,
    parameter int CORDIC_STAGES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ogii_pix_if.sink      i_pix,
    ogii_res_if.source    o_res,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    localparam int CW = $clog2(MAX_WIDTH);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_GRAD = 8'b0000_0010,
        S_CORD = 8'b0000_0100,
        S_MAG  = 8'b0000_1000,
        S_RND  = 8'b0001_0000,
        S_HI   = 8'b0010_0000,
        S_ACC  = 8'b0100_0000,
        S_SUM  = 8'b1000_0000
    } t_state;

    t_state r_state;
    logic [CW-1:0] r_col, n_col;
    logic [9:0]    r_row, n_row;
    logic [10:0]   r_width, r_height;
    logic signed [ogii_pkg::PIX_W-1:0] r_pix;
    logic [ogii_pkg::ANG_W-1:0]  r_ang;
    logic [ogii_pkg::CX_W-2:0]   r_xmag;
    logic [53:0]                 r_prod;
    logic [ogii_pkg::MAG_W-1:0]  r_mag, r_hi;
    ogii_pkg::t_sums             r_run;
    ogii_pkg::t_sums             r_out_sums;
    logic [9:0]                  r_out_col, r_out_row, r_out_row2;
    logic                        r_out_valid, r_out_more;

    logic in_fire, out_fire, cfg_wr;
    logic [12:0] w_raw, w_eff, col_ext;
    logic [10:0] h_eff, row_ext;
    logic last_col, last_row, interior, right_ok;
    logic signed [ogii_pkg::PIX_W-1:0] lb_left, lb_up, lb_right, left, right;
    logic signed [16:0] dx, dy;
    logic signed [ogii_pkg::CX_W-1:0] gx, gy, fx, fy;
    logic fold;
    ogii_pkg::t_cord_req cord_req;
    ogii_pkg::t_cord_rsp cord_rsp;
    ogii_pkg::t_sums prev_rd, sums;
    logic [53:0] rnd;
    logic [37:0] hi_prod;
    logic [3:0] b0, b1;
    logic [ogii_pkg::MAG_W-1:0] lo;
    logic lb_wr, im_wr, advance;

    assign in_fire  = i_pix.valid && i_pix.ready;
    assign out_fire = o_res.valid && o_res.ready;
    assign cfg_wr   = psel && penable && pwrite;
    assign i_pix.ready = (r_state == S_IDLE);

    // configuration port
    assign pready = 1'b1;
    always_comb begin
        case (ogii_pkg::t_reg_idx'(paddr[2]))
            ogii_pkg::REG_IMAGE_WIDTH:  prdata = {21'd0, r_width};
            ogii_pkg::REG_IMAGE_HEIGHT: prdata = {21'd0, r_height};
            default:                    prdata = 32'd0;
        endcase
    end

    // effective frame size and position flags
    assign w_raw   = 13'(r_width);
    assign w_eff   = (w_raw < 13'd3) ? 13'd3 :
                     (w_raw > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : w_raw;
    assign h_eff   = (r_height < 11'd3) ? 11'd3 :
                     (r_height > 11'd1024) ? 11'd1024 : r_height;
    assign col_ext = 13'(r_col);
    assign row_ext = 11'(r_row);
    assign last_col = col_ext >= w_eff - 13'd1;
    assign last_row = row_ext >= h_eff - 11'd1;
    assign right_ok = col_ext != 13'(MAX_WIDTH - 1);
    assign interior = (r_col != '0) && (col_ext < w_eff - 13'd1) &&
                      (r_row >= 10'd2) && (row_ext < h_eff);

    // next raster position
    always_comb begin
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? 10'd0 : r_row + 10'd1;
        end else begin
            n_col = r_col + 1'b1;
            n_row = r_row;
        end
    end

    // memories
    assign lb_wr = (r_state == S_GRAD);
    ogii_linebuf #(.DEPTH(MAX_WIDTH)) u_linebuf (
        .i_clk    (i_clk),
        .i_rd_en  (in_fire),
        .i_wr_en  (lb_wr),
        .i_addr   (r_col),
        .i_wr_pix (r_pix),
        .o_left   (lb_left),
        .o_up     (lb_up),
        .o_right  (lb_right)
    );

    ogii_intmem #(.DEPTH(MAX_WIDTH)) u_intmem (
        .i_clk     (i_clk),
        .i_rd_en   (in_fire),
        .i_wr_en   (im_wr),
        .i_addr    (r_col),
        .i_wr_data (sums),
        .o_rd_data (prev_rd)
    );

    // central differences and fold to the upper half plane
    assign left  = (r_col == '0) ? '0 : lb_left;
    assign right = right_ok ? lb_right : '0;
    assign dx = {right[15], right} - {left[15], left};
    assign dy = {r_pix[15], r_pix} - {lb_up[15], lb_up};
    assign gx = {{(ogii_pkg::CX_W - 25){dx[16]}}, dx, 8'd0};
    assign gy = {{(ogii_pkg::CX_W - 25){dy[16]}}, dy, 8'd0};
    assign fold = gy[ogii_pkg::CX_W-1] || ((gy == '0) && gx[ogii_pkg::CX_W-1]);
    assign fx = fold ? -gx : gx;
    assign fy = fold ? -gy : gy;

    always_comb begin
        cord_req.start = (r_state == S_GRAD) && interior;
        if (fx[ogii_pkg::CX_W-1]) begin
            cord_req.x = fy;
            cord_req.y = -fx;
            cord_req.z = ogii_pkg::ANG_HALF_PI;
        end else begin
            cord_req.x = fx;
            cord_req.y = fy;
            cord_req.z = '0;
        end
    end

    ogii_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cord_req),
        .o_rsp   (cord_rsp)
    );

    // magnitude rounding, bin split
    assign rnd     = r_prod + (54'd1 << 31);
    assign hi_prod = 38'(r_mag) * 38'(r_ang[15:0]);
    assign b0      = r_ang[19:16];
    assign b1      = (b0 == 4'd8) ? 4'd0 : b0 + 4'd1;
    assign lo      = r_mag - r_hi;

    // integral sums at this pixel
    always_comb begin
        for (int b = 0; b < ogii_pkg::NBINS; b++) begin
            sums[b] = ogii_pkg::sat_add((r_row == 10'd1) ? '0 : prev_rd[b], r_run[b]);
        end
    end

    assign advance = (r_state == S_SUM) && ((r_row == 10'd0) || !r_out_valid);
    assign im_wr   = advance && (r_row != 10'd0);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_width     <= 11'd640;
            r_height    <= 11'd480;
            r_run       <= '0;
            r_out_valid <= 1'b0;
            r_out_more  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (ogii_pkg::t_reg_idx'(paddr[2]))
                    ogii_pkg::REG_IMAGE_WIDTH:  r_width  <= pwdata[10:0];
                    ogii_pkg::REG_IMAGE_HEIGHT: r_height <= pwdata[10:0];
                    default: ;
                endcase
            end
            // output register: first of a pair turns into the last-row copy
            if (out_fire) begin
                if (r_out_more) begin
                    r_out_more <= 1'b0;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) r_state <= S_GRAD;
                end
                S_GRAD: begin
                    if (r_col == '0) r_run <= '0;
                    r_state <= interior ? S_CORD : S_SUM;
                end
                S_CORD: begin
                    if (cord_rsp.done) r_state <= S_MAG;
                end
                S_MAG:  r_state <= S_RND;
                S_RND:  r_state <= S_HI;
                S_HI:   r_state <= S_ACC;
                S_ACC: begin
                    r_run[b0] <= ogii_pkg::sat_add(r_run[b0], ogii_pkg::SUM_W'(lo));
                    r_run[b1] <= ogii_pkg::sat_add(r_run[b1], ogii_pkg::SUM_W'(r_hi));
                    r_state   <= S_SUM;
                end
                S_SUM: begin
                    if (advance) begin
                        r_col   <= n_col;
                        r_row   <= n_row;
                        r_state <= S_IDLE;
                        if (r_row != 10'd0) begin
                            r_out_valid <= 1'b1;
                            r_out_more  <= last_row;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) r_pix <= i_pix.filtered_pixel;
        if (r_state == S_CORD && cord_rsp.done) begin
            if (cord_rsp.z[ogii_pkg::CZ_W-1] || (cord_rsp.z >= ogii_pkg::ANG_PI)) begin
                r_ang <= '0;
            end else begin
                r_ang <= cord_rsp.z[ogii_pkg::ANG_W-1:0];
            end
            r_xmag <= cord_rsp.x[ogii_pkg::CX_W-1] ? '0 : cord_rsp.x[ogii_pkg::CX_W-2:0];
        end
        if (r_state == S_MAG) r_prod <= 54'(r_xmag) * 54'(ogii_pkg::KINV_Q24);
        if (r_state == S_RND) r_mag  <= rnd[53:32];
        if (r_state == S_HI)  r_hi   <= hi_prod[37:16];
        if (out_fire && r_out_more) r_out_row <= r_out_row2;
        if (im_wr) begin
            r_out_sums <= sums;
            r_out_col  <= 10'(r_col);
            r_out_row  <= r_row - 10'd1;
            r_out_row2 <= r_row;
        end
    end

    // result channel
    assign o_res.valid       = r_out_valid;
    assign o_res.bin_sum_0   = r_out_sums[0];
    assign o_res.bin_sum_1   = r_out_sums[1];
    assign o_res.bin_sum_2   = r_out_sums[2];
    assign o_res.bin_sum_3   = r_out_sums[3];
    assign o_res.bin_sum_4   = r_out_sums[4];
    assign o_res.bin_sum_5   = r_out_sums[5];
    assign o_res.bin_sum_6   = r_out_sums[6];
    assign o_res.bin_sum_7   = r_out_sums[7];
    assign o_res.bin_sum_8   = r_out_sums[8];
    assign o_res.out_column  = r_out_col;
    assign o_res.out_row     = r_out_row;
    assign o_res.last_of_run = !r_out_more;
endmodule

// ----- rtl/core/ogii_chk.sv -----
// port-level checks for the oriented gradient integral image block
`timescale 1ns / 1ps
module ogii_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_last,
    input logic [9:0]  i_out_col,
    input logic [9:0]  i_out_row,
    input logic [39:0] i_out_bin0
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_col) &&
        $stable(i_out_row) && $stable(i_out_bin0))
        else $error("stalled result changed");

    // the first of a pair is followed at once by its last-row copy
    a_pair_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> i_out_valid && i_out_last &&
        $stable(i_out_col) && $stable(i_out_bin0))
        else $error("second result of a pair missing or different");

    // the copy names the row one below
    a_pair_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> i_out_row == $past(i_out_row) + 10'd1)
        else $error("second result of a pair has the wrong row");

    // one pixel at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("pixel taken while one is in work");
endmodule

bind oriented_gradient_integral_images ogii_chk u_ogii_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_last  (o_res.last_of_run),
    .i_out_col   (o_res.out_column),
    .i_out_row   (o_res.out_row),
    .i_out_bin0  (o_res.bin_sum_0)
);

// ----- test/testbench.sv -----
// testbench for the oriented gradient integral image block: directed and random frames
`timescale 1ns / 1ps
module testbench;

    localparam int    DIM_MAX     = 1024;
    localparam int    ROTATIONS   = 16;
    localparam int    SETTLE      = 40;
    localparam int    CYCLE_LIMIT = 4000000;
    localparam longint unsigned CLIP = 64'hFF_FFFF_FFFF;
    localparam longint unsigned GAIN_INV = 64'd10188014;
    localparam longint HALF_TURN = 589824;
    localparam longint QUARTER_TURN = 294912;

    // pixel content styles for random frames
    typedef enum int {
        TEX_NOISE,
        TEX_FLAT_NOISE,
        TEX_RAMP,
        TEX_SPIKES
    } t_texture;

    typedef struct packed {
        ogii_pkg::t_sums sums;
        logic [9:0]      col;
        logic [9:0]      row;
        logic            last;
    } t_integral_px;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ogii_pix_if pix ();
    ogii_res_if res ();

    oriented_gradient_integral_images DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // predictor state
    logic signed [15:0] line_above [DIM_MAX];
    logic signed [15:0] line_two_above [DIM_MAX];
    longint unsigned    integral_above [DIM_MAX][ogii_pkg::NBINS];
    longint unsigned    row_bins [ogii_pkg::NBINS];
    int                 col_pos;
    int                 row_pos;
    logic [10:0]        width_reg;
    logic [10:0]        height_reg;

    t_integral_px integrals_due[$];
    int           mismatches;
    int           pixels_sent;
    int           results_seen;
    int           frames_run;
    int           cycles;
    bit           no_gaps;

    const longint arctan_steps [24] = '{
        147456, 87048, 45994, 23347, 11719, 5865, 2933, 1467,
        733, 367, 183, 92, 46, 23, 11, 6, 3, 1, 1, 0, 0, 0, 0, 0
    };

    function automatic longint unsigned add_clip(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > CLIP) ? CLIP : s;
    endfunction

    function automatic int clamp_dim(logic [10:0] v);
        return (v < 3) ? 3 : ((v > DIM_MAX) ? DIM_MAX : int'(v));
    endfunction

    // magnitude as an integer and orientation in bin units with 16 fraction bits
    task automatic gradient_polar(input longint dx, input longint dy,
                                  output longint unsigned mag, output longint ang);
        longint x, y, z, t, sx, sy;
        x = dx * 256;
        y = dy * 256;
        z = 0;
        if (y < 0 || (y == 0 && x < 0)) begin
            x = -x;
            y = -y;
        end
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = QUARTER_TURN;
        end
        for (int i = 0; i < ROTATIONS; i++) begin
            sx = x >>> i;
            sy = y >>> i;
            if (y >= 0) begin
                x += sy;
                y -= sx;
                z += arctan_steps[i];
            end else begin
                x -= sy;
                y += sx;
                z -= arctan_steps[i];
            end
        end
        if (z < 0 || z >= HALF_TURN) z = 0;
        ang = z;
        mag = ((x < 0 ? 64'd0 : longint'(x)) * GAIN_INV + 64'h8000_0000) >> 32;
    endtask

    // expected integral results for one accepted pixel
    task automatic predict_integrals(input logic signed [15:0] p);
        int               w, h, c, r, y, b0, b1, copies;
        longint           left, right, up, ang;
        longint unsigned  mag, hi;
        t_integral_px     e;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        c = col_pos;
        r = row_pos;
        left = 0;
        right = 0;
        up = 0;
        if (c >= 1) left = line_two_above[c-1];
        if (c + 1 < DIM_MAX) right = line_above[c+1];
        up = line_two_above[c];
        line_two_above[c] = line_above[c];
        line_above[c] = p;

        if (r >= 1) begin
            y = r - 1;
            if (c == 0) foreach (row_bins[b]) row_bins[b] = 0;
            // interior pixels only
            if (c >= 1 && c + 1 < w && y >= 1 && y + 1 < h) begin
                gradient_polar(right - left, longint'(p) - up, mag, ang);
                b0 = int'(ang >> 16);
                b1 = (b0 + 1 >= ogii_pkg::NBINS) ? 0 : b0 + 1;
                hi = (mag * longint'(ang & 16'hFFFF)) >> 16;
                row_bins[b0] = add_clip(row_bins[b0], mag - hi);
                row_bins[b1] = add_clip(row_bins[b1], hi);
            end
            for (int b = 0; b < ogii_pkg::NBINS; b++) begin
                e.sums[b] = 40'(add_clip((y == 0) ? 64'd0 : integral_above[c][b],
                                         row_bins[b]));
                integral_above[c][b] = e.sums[b];
            end
            e.col = c[9:0];
            e.row = y[9:0];
            copies = (r >= h - 1) ? 2 : 1;
            e.last = (copies == 1);
            integrals_due.push_back(e);
            // last row is emitted a second time under its own row number
            if (copies == 2) begin
                e.row = r[9:0];
                e.last = 1'b1;
                integrals_due.push_back(e);
            end
        end

        if (c >= w - 1) begin
            col_pos = 0;
            row_pos = (r >= h - 1) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want,
                 results_seen);
        mismatches++;
    endtask

    // send one pixel transaction and predict its results
    task automatic send_pixel(input logic signed [15:0] v);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.filtered_pixel <= v;
        do @(posedge i_clk); while (!pix.ready);
        predict_integrals(v);
        pixels_sent++;
    endtask

    task automatic end_pixels();
        pix.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        end_pixels();
        while (integrals_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic reg_access(input ogii_pkg::t_reg_idx idx, input bit wr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // write both size registers, read them back, mirror them in the predictor
    task automatic set_image_size(input logic [10:0] w, input logic [10:0] h);
        logic [31:0] rd;
        wait_idle();
        reg_access(ogii_pkg::REG_IMAGE_WIDTH, 1'b1, {21'd0, w}, rd);
        width_reg = w;
        reg_access(ogii_pkg::REG_IMAGE_HEIGHT, 1'b1, {21'd0, h}, rd);
        height_reg = h;
        reg_access(ogii_pkg::REG_IMAGE_WIDTH, 1'b0, 32'd0, rd);
        if (rd[10:0] !== w) report_mismatch("image_width readback", rd[10:0], w);
        reg_access(ogii_pkg::REG_IMAGE_HEIGHT, 1'b0, 32'd0, rd);
        if (rd[10:0] !== h) report_mismatch("image_height readback", rd[10:0], h);
    endtask

    function automatic logic signed [15:0] texture_pixel(t_texture tex, int c, int r,
                                                         int base, int sx, int sy);
        case (tex)
            TEX_NOISE:      return 16'($urandom);
            TEX_FLAT_NOISE: return 16'(base + $signed($urandom_range(0, 400)) - 200);
            TEX_RAMP:       return 16'(base + c * sx + r * sy);
            default:        return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'(base);
        endcase
    endfunction

    task automatic run_frame(input t_texture tex);
        int w, h, base, sx, sy;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        base = $urandom;
        sx = $signed($urandom_range(0, 4000)) - 2000;
        sy = $signed($urandom_range(0, 4000)) - 2000;
        no_gaps = ($urandom_range(0, 3) == 0);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                send_pixel(texture_pixel(tex, c, r, base, sx, sy));
        frames_run++;
    endtask

    // zero frame, flat gradient along the negative x axis, and extreme values
    task automatic test_directed_frames();
        logic signed [15:0] neg_x [9] = '{0, 7, 0, 100, 0, -100, 0, 7, 0};
        logic signed [15:0] extremes [16] = '{
            16'sh7FFF, 16'sh8000, 0, 1, -1, 16'sh7FFF, 16'sh8000, 16'sh8000,
            0, 0, 16'sh7FFF, 0, 16'sh8000, 1, 0, 16'sh7FFF
        };
        no_gaps = 1'b0;
        set_image_size(11'd0, 11'd1);
        repeat (9) send_pixel(16'sd0);
        set_image_size(11'd3, 11'd3);
        foreach (neg_x[i]) send_pixel(neg_x[i]);
        set_image_size(11'd4, 11'd4);
        foreach (extremes[i]) send_pixel(extremes[i]);
    endtask

    // largest register values read back, then a wide frame
    task automatic test_extreme_sizes();
        set_image_size(11'd2047, 11'd2047);
        set_image_size(11'd320, 11'd3);
        run_frame(TEX_NOISE);
    endtask

    task automatic test_random_frames(input int pixel_goal);
        int start;
        start = pixels_sent;
        while (pixels_sent - start < pixel_goal) begin
            if ($urandom_range(0, 2) == 0)
                set_image_size(11'($urandom_range(3, 24)), 11'($urandom_range(3, 10)));
            else if (frames_run == 0 || $urandom_range(0, 9) == 0)
                set_image_size(11'($urandom_range(0, 40)), 11'($urandom_range(0, 12)));
            run_frame(t_texture'($urandom_range(0, 3)));
        end
    endtask

    // result side: random back-pressure and check against the oldest expectation
    int stall_left;
    always @(posedge i_clk) begin
        t_integral_px e;
        logic [39:0]  got [ogii_pkg::NBINS];
        if (res.valid && res.ready) begin
            results_seen++;
            if (integrals_due.size() == 0) begin
                report_mismatch("unexpected result", res.out_column, 0);
            end else begin
                e = integrals_due.pop_front();
                got = '{res.bin_sum_0, res.bin_sum_1, res.bin_sum_2, res.bin_sum_3,
                        res.bin_sum_4, res.bin_sum_5, res.bin_sum_6, res.bin_sum_7,
                        res.bin_sum_8};
                for (int b = 0; b < ogii_pkg::NBINS; b++)
                    if (got[b] !== e.sums[b])
                        report_mismatch($sformatf("bin_sum_%0d", b), got[b], e.sums[b]);
                if (res.out_column !== e.col)
                    report_mismatch("out_column", res.out_column, e.col);
                if (res.out_row !== e.row)
                    report_mismatch("out_row", res.out_row, e.row);
                if (res.last_of_run !== e.last)
                    report_mismatch("last_of_run", res.last_of_run, e.last);
            end
            stall_left = no_gaps ? 0 : $urandom_range(0, 10);
        end else if (stall_left > 0) begin
            stall_left--;
        end
        res.ready <= (stall_left == 0);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pix.valid = 1'b0;
        pix.filtered_pixel = '0;
        res.ready = 1'b0;
        stall_left = 0;
        cycles = 0;
        mismatches = 0;
        pixels_sent = 0;
        results_seen = 0;
        frames_run = 0;
        no_gaps = 1'b0;
        col_pos = 0;
        row_pos = 0;
        width_reg = 11'd640;
        height_reg = 11'd480;
        for (int i = 0; i < DIM_MAX; i++) begin
            line_above[i] = 0;
            line_two_above[i] = 0;
            for (int b = 0; b < ogii_pkg::NBINS; b++) integral_above[i][b] = 0;
        end
        foreach (row_bins[b]) row_bins[b] = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_frames();
        test_random_frames(850);
        test_extreme_sizes();

        wait_idle();
        $display("covered %0d pixels in %0d frames, %0d results checked",
                 pixels_sent, frames_run, results_seen);
        $display("sizes from clamped minimum up to 320 wide, %0d mismatches",
                 mismatches);
        if (mismatches == 0 && integrals_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
